// File: hdl/movdec_pkg.sv
// Shared types and constants of the MOV instruction decoder.
package movdec_pkg;

  localparam logic [7:0] OP_RM_LO   = 8'h88;
  localparam logic [7:0] OP_RM_HI   = 8'h8B;
  localparam logic [7:0] OP_IMM_LO  = 8'hB0;
  localparam logic [7:0] OP_IMM_HI  = 8'hBF;
  localparam logic [7:0] OP_ACC_LO  = 8'hA0;
  localparam logic [7:0] OP_ACC_HI  = 8'hA3;

  localparam logic [1:0] MOD_NO_DISP = 2'd0;
  localparam logic [1:0] MOD_DISP8   = 2'd1;
  localparam logic [1:0] MOD_REG     = 2'd3;
  localparam logic [2:0] RM_DIRECT   = 3'd6;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 48;

  typedef enum logic [1:0] {
    FORM_REGMEM = 2'd0,
    FORM_IMM    = 2'd1,
    FORM_LOAD   = 2'd2,
    FORM_STORE  = 2'd3
  } form_e;

  // Classified instruction handed from the front to the back
  typedef struct packed {
    form_e       form;
    logic [7:0]  opcode;
    logic [7:0]  modrm;
    logic [15:0] value;
    logic        disp8;
    logic        trunc;
  } dec_raw_t;

  // Decoded record as it leaves the block
  typedef struct packed {
    form_e       form;
    logic        to_register;
    logic        wide;
    logic [2:0]  reg_field;
    logic [1:0]  mode;
    logic [2:0]  rm_code;
    logic        direct_address;
    logic [15:0] offset_value;
    logic [15:0] immediate;
    logic        truncated;
  } dec_rec_t;

endpackage

// File: hdl/movdec_front.sv
// Byte phase machine: collects the bytes of each MOV and classifies it.
module movdec_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                byte_valid_i,
  input  logic [7:0]          byte_i,
  input  logic                end_i,
  output logic                push_o,
  output movdec_pkg::dec_raw_t raw_o
);
  import movdec_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_MODRM   = 3'd1,
    PH_DISP_LO = 3'd2,
    PH_DISP_HI = 3'd3,
    PH_IMM_LO  = 3'd4,
    PH_IMM_HI  = 3'd5,
    PH_ADDR_LO = 3'd6,
    PH_ADDR_HI = 3'd7
  } phase_e;

  phase_e     phase_q, phase_d, step_phase;
  logic [7:0] opcode_q, opcode_d;
  logic [7:0] modrm_q, modrm_d;
  logic [7:0] low_q, low_d;
  logic       done;
  dec_raw_t   rec;

  always_comb begin
    step_phase = phase_q;
    opcode_d   = opcode_q;
    modrm_d    = modrm_q;
    low_d      = low_q;
    done       = 1'b0;
    rec.form   = FORM_REGMEM;
    rec.opcode = opcode_q;
    rec.modrm  = modrm_q;
    rec.value  = 16'h0000;
    rec.disp8  = 1'b0;
    rec.trunc  = 1'b0;
    case (phase_q)
      PH_IDLE: begin
        if (byte_i inside {[OP_RM_LO:OP_RM_HI]}) begin
          opcode_d   = byte_i;
          step_phase = PH_MODRM;
        end else if (byte_i inside {[OP_IMM_LO:OP_IMM_HI]}) begin
          opcode_d   = byte_i;
          step_phase = PH_IMM_LO;
        end else if (byte_i inside {[OP_ACC_LO:OP_ACC_HI]}) begin
          opcode_d   = byte_i;
          step_phase = PH_ADDR_LO;
        end
      end
      PH_MODRM: begin
        modrm_d   = byte_i;
        rec.modrm = byte_i;
        if (byte_i[7:6] == MOD_REG ||
            (byte_i[7:6] == MOD_NO_DISP && byte_i[2:0] != RM_DIRECT)) begin
          done       = 1'b1;
          step_phase = PH_IDLE;
        end else begin
          step_phase = PH_DISP_LO;
        end
      end
      PH_DISP_LO: begin
        low_d = byte_i;
        if (modrm_q[7:6] == MOD_DISP8) begin
          rec.value  = {8'h00, byte_i};
          rec.disp8  = 1'b1;
          done       = 1'b1;
          step_phase = PH_IDLE;
        end else begin
          step_phase = PH_DISP_HI;
        end
      end
      PH_DISP_HI: begin
        rec.value  = {byte_i, low_q};
        done       = 1'b1;
        step_phase = PH_IDLE;
      end
      PH_IMM_LO: begin
        low_d    = byte_i;
        rec.form = FORM_IMM;
        if (!opcode_q[3]) begin
          rec.value  = {8'h00, byte_i};
          done       = 1'b1;
          step_phase = PH_IDLE;
        end else begin
          step_phase = PH_IMM_HI;
        end
      end
      PH_IMM_HI: begin
        rec.form   = FORM_IMM;
        rec.value  = {byte_i, low_q};
        done       = 1'b1;
        step_phase = PH_IDLE;
      end
      PH_ADDR_LO: begin
        low_d      = byte_i;
        step_phase = PH_ADDR_HI;
      end
      PH_ADDR_HI: begin
        rec.form   = opcode_q[1] ? FORM_STORE : FORM_LOAD;
        rec.value  = {byte_i, low_q};
        done       = 1'b1;
        step_phase = PH_IDLE;
      end
      default: begin
        step_phase = PH_IDLE;
      end
    endcase

    push_o = byte_valid_i && done;
    // Cut short: report what opcode and collected ModRM give
    if (end_i && !done && step_phase != PH_IDLE) begin
      push_o     = byte_valid_i;
      rec.opcode = opcode_d;
      rec.modrm  = (step_phase == PH_MODRM) ? 8'h00 : modrm_d;
      rec.value  = 16'h0000;
      rec.disp8  = 1'b0;
      rec.trunc  = 1'b1;
      case (step_phase)
        PH_IMM_LO, PH_IMM_HI:     rec.form = FORM_IMM;
        PH_ADDR_LO, PH_ADDR_HI:   rec.form = opcode_d[1] ? FORM_STORE : FORM_LOAD;
        default:                  rec.form = FORM_REGMEM;
      endcase
    end
    phase_d = end_i ? PH_IDLE : step_phase;
    raw_o   = rec;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      opcode_q <= 8'h00;
      modrm_q  <= 8'h00;
      low_q    <= 8'h00;
    end else if (byte_valid_i) begin
      phase_q  <= phase_d;
      opcode_q <= opcode_d;
      modrm_q  <= modrm_d;
      low_q    <= low_d;
    end
  end

endmodule

// File: hdl/movdec_queue.sv
// Small queue of classified instructions between front and back.
module movdec_queue #(
  parameter int unsigned Depth = movdec_pkg::QUEUE_DEPTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  movdec_pkg::dec_raw_t push_data_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 empty_o,
  output movdec_pkg::dec_raw_t pop_data_o
);
  import movdec_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  dec_raw_t        mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o     = (cnt_q == FullCnt);
  assign empty_o    = (cnt_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: hdl/movdec_back.sv
// Field extraction of a classified instruction into the output register.
module movdec_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 avail_i,
  input  movdec_pkg::dec_raw_t raw_i,
  output logic                 pop_o,
  output logic                 valid_o,
  input  logic                 ready_i,
  output movdec_pkg::dec_rec_t rec_o
);
  import movdec_pkg::*;

  logic     valid_q, valid_d;
  dec_rec_t rec_q, rec_d;
  logic [1:0] mode;
  logic [2:0] rm;

  assign mode  = raw_i.modrm[7:6];
  assign rm    = raw_i.modrm[2:0];
  assign pop_o = avail_i && (!valid_q || ready_i);

  always_comb begin
    rec_d           = '0;
    rec_d.form      = raw_i.form;
    rec_d.truncated = raw_i.trunc;
    case (raw_i.form)
      FORM_REGMEM: begin
        rec_d.to_register    = raw_i.opcode[1];
        rec_d.wide           = raw_i.opcode[0];
        rec_d.reg_field      = raw_i.modrm[5:3];
        rec_d.mode           = mode;
        rec_d.rm_code        = rm;
        rec_d.direct_address = (mode == MOD_NO_DISP) && (rm == RM_DIRECT);
        rec_d.offset_value   = raw_i.disp8 ? {{8{raw_i.value[7]}}, raw_i.value[7:0]}
                                           : raw_i.value;
      end
      FORM_IMM: begin
        rec_d.to_register = 1'b1;
        rec_d.wide        = raw_i.opcode[3];
        rec_d.reg_field   = raw_i.opcode[2:0];
        rec_d.immediate   = raw_i.value;
      end
      FORM_LOAD, FORM_STORE: begin
        rec_d.to_register  = (raw_i.form == FORM_LOAD);
        rec_d.wide         = raw_i.opcode[0];
        rec_d.offset_value = raw_i.value;
      end
      default: begin
        rec_d.form = FORM_REGMEM;
      end
    endcase
    valid_d = pop_o ? 1'b1 : (valid_q && !ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      rec_q <= rec_d;
    end
  end

  assign valid_o = valid_q;
  assign rec_o   = rec_q;

endmodule

// File: hdl/mov_instruction_decoder.sv
// Top level of the 8086 MOV instruction decoder.
//
//  channel  | dir | words
//  s_axis   | in  | one code byte per word, tlast on the final byte of the stream
//  m_axis   | out | one decoded MOV record per word, tuser flags a truncated one
//
//  Takes one byte per cycle while s_axis_tready is high; the phase machine advances on each accepted word.
//  A record is queued on its last byte; m_axis_tvalid rises when the back stage registers it.
//  Reset clears the phase machine, the queue and the output valid.
//  s_axis_tready drops only while the queue is full, which happens when m_axis stalls.
module mov_instruction_decoder #(
  parameter int unsigned QueueDepth = movdec_pkg::QUEUE_DEPTH
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [movdec_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // [7:0] code_byte
  input  logic                                 s_axis_tlast,  // stream_end
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [1:0] form, [2] to_register, [3] wide, [6:4] register field, [8:7] mode,
  // [11:9] rm_code, [12] direct_address, [28:13] offset_value,
  // [44:29] immediate, [47:45] zero
  output logic [movdec_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  output logic                                 m_axis_tuser   // [0] truncated
);
  import movdec_pkg::*;

  logic     accept, push, full, empty, pop;
  dec_raw_t raw_in, raw_out;
  dec_rec_t rec;

  assign s_axis_tready = !full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  movdec_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (accept),
    .byte_i       (s_axis_tdata),
    .end_i        (s_axis_tlast),
    .push_o       (push),
    .raw_o        (raw_in)
  );

  movdec_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (raw_in),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .pop_data_o  (raw_out)
  );

  movdec_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .avail_i (!empty),
    .raw_i   (raw_out),
    .pop_o   (pop),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .rec_o   (rec)
  );

  assign m_axis_tdata = {3'b000, rec.immediate, rec.offset_value, rec.direct_address,
                         rec.rm_code, rec.mode, rec.reg_field, rec.wide,
                         rec.to_register, rec.form};
  assign m_axis_tuser = rec.truncated;

endmodule

// File: verif/mov_instruction_decoder_test.sv
// Testbench of the MOV decoder: directed and random byte streams, records checked field by field.
module mov_instruction_decoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  import movdec_pkg::*;

  localparam int unsigned RANDOM_WORDS   = 1350;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam logic [1:0]  MOD_DISP16     = 2'd2;

  typedef enum logic [2:0] {
    AWAIT_OPCODE,
    AWAIT_MODRM,
    AWAIT_DISP_LO,
    AWAIT_DISP_HI,
    AWAIT_IMM_LO,
    AWAIT_IMM_HI,
    AWAIT_ADDR_LO,
    AWAIT_ADDR_HI
  } phase_e;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
    logic       typed;
    dec_rec_t   want;
  } code_word_t;

  localparam dec_rec_t NO_REC = '0;

  localparam int unsigned DIRECTED_LEN = 26;
  localparam code_word_t DIRECTED [DIRECTED_LEN] = '{
    '{8'h89, 1'b0, 1'b0, NO_REC},
    '{8'hC0, 1'b0, 1'b1,
      '{FORM_REGMEM, 1'b0, 1'b1, 3'd0, 2'd3, 3'd0, 1'b0, 16'h0000, 16'h0000, 1'b0}},
    '{8'h8B, 1'b0, 1'b0, NO_REC},
    '{8'h06, 1'b0, 1'b0, NO_REC},
    '{8'h34, 1'b0, 1'b0, NO_REC},
    '{8'h12, 1'b0, 1'b1,
      '{FORM_REGMEM, 1'b1, 1'b1, 3'd0, 2'd0, 3'd6, 1'b1, 16'h1234, 16'h0000, 1'b0}},
    '{8'h88, 1'b0, 1'b0, NO_REC},
    '{8'h47, 1'b0, 1'b0, NO_REC},
    '{8'h80, 1'b0, 1'b1,
      '{FORM_REGMEM, 1'b0, 1'b0, 3'd0, 2'd1, 3'd7, 1'b0, 16'hFF80, 16'h0000, 1'b0}},
    '{8'hBF, 1'b0, 1'b0, NO_REC},
    '{8'hFF, 1'b0, 1'b0, NO_REC},
    '{8'hFF, 1'b0, 1'b1,
      '{FORM_IMM, 1'b1, 1'b1, 3'd7, 2'd0, 3'd0, 1'b0, 16'h0000, 16'hFFFF, 1'b0}},
    '{8'hA3, 1'b0, 1'b0, NO_REC},
    '{8'hFF, 1'b0, 1'b0, NO_REC},
    '{8'hFF, 1'b0, 1'b1,
      '{FORM_STORE, 1'b0, 1'b1, 3'd0, 2'd0, 3'd0, 1'b0, 16'hFFFF, 16'h0000, 1'b0}},
    '{8'h00, 1'b0, 1'b0, NO_REC},
    '{8'hF4, 1'b1, 1'b0, NO_REC},
    '{8'h89, 1'b1, 1'b1,
      '{FORM_REGMEM, 1'b0, 1'b1, 3'd0, 2'd0, 3'd0, 1'b0, 16'h0000, 16'h0000, 1'b1}},
    '{8'hBB, 1'b0, 1'b0, NO_REC},
    '{8'h12, 1'b1, 1'b1,
      '{FORM_IMM, 1'b1, 1'b1, 3'd3, 2'd0, 3'd0, 1'b0, 16'h0000, 16'h0000, 1'b1}},
    '{8'h8A, 1'b0, 1'b0, NO_REC},
    '{8'h80, 1'b1, 1'b0, NO_REC},
    '{8'hA0, 1'b0, 1'b0, NO_REC},
    '{8'h00, 1'b1, 1'b0, NO_REC},
    '{8'h8A, 1'b0, 1'b0, NO_REC},
    '{8'hD8, 1'b1, 1'b0, NO_REC}
  };

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   s_axis_tlast  = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;

  phase_e      phase        = AWAIT_OPCODE;
  logic [7:0]  held_opcode  = 8'h00;
  logic [7:0]  held_modrm   = 8'h00;
  logic [7:0]  held_low     = 8'h00;

  dec_rec_t    pending_records[$];
  code_word_t  byte_stream[$];
  int unsigned error_count    = 0;
  int unsigned record_count   = 0;
  int unsigned stalled_cycles = 0;

  mov_instruction_decoder u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic dec_rec_t regmem_rec(logic [7:0] op, logic [7:0] modrm,
                                          logic [15:0] offset, logic trunc);
    dec_rec_t rec;
    rec                = '0;
    rec.form           = FORM_REGMEM;
    rec.to_register    = op[1];
    rec.wide           = op[0];
    rec.reg_field      = modrm[5:3];
    rec.mode           = modrm[7:6];
    rec.rm_code        = modrm[2:0];
    rec.direct_address = (modrm[7:6] == MOD_NO_DISP) && (modrm[2:0] == RM_DIRECT);
    rec.offset_value   = offset;
    rec.truncated      = trunc;
    return rec;
  endfunction

  function automatic dec_rec_t imm_rec(logic [7:0] op, logic [15:0] value, logic trunc);
    dec_rec_t rec;
    rec             = '0;
    rec.form        = FORM_IMM;
    rec.to_register = 1'b1;
    rec.wide        = op[3];
    rec.reg_field   = op[2:0];
    rec.immediate   = value;
    rec.truncated   = trunc;
    return rec;
  endfunction

  function automatic dec_rec_t acc_rec(logic [7:0] op, logic [15:0] addr, logic trunc);
    dec_rec_t rec;
    rec              = '0;
    rec.form         = op[1] ? FORM_STORE : FORM_LOAD;
    rec.to_register  = ~op[1];
    rec.wide         = op[0];
    rec.offset_value = addr;
    rec.truncated    = trunc;
    return rec;
  endfunction

  // Advance the decode phase by one code byte; return 1 when a record completes or is cut short by last.
  function automatic bit decode_byte(input logic [7:0] b, input logic last,
                                     output dec_rec_t rec);
    bit produced;
    produced = 1'b0;
    rec      = '0;
    case (phase)
      AWAIT_OPCODE: begin
        if (b >= OP_RM_LO && b <= OP_RM_HI) begin
          held_opcode = b;
          phase       = AWAIT_MODRM;
        end else if (b >= OP_IMM_LO && b <= OP_IMM_HI) begin
          held_opcode = b;
          phase       = AWAIT_IMM_LO;
        end else if (b >= OP_ACC_LO && b <= OP_ACC_HI) begin
          held_opcode = b;
          phase       = AWAIT_ADDR_LO;
        end
      end
      AWAIT_MODRM: begin
        held_modrm = b;
        if (b[7:6] == MOD_REG || (b[7:6] == MOD_NO_DISP && b[2:0] != RM_DIRECT)) begin
          rec      = regmem_rec(held_opcode, b, 16'h0000, 1'b0);
          produced = 1'b1;
          phase    = AWAIT_OPCODE;
        end else begin
          phase = AWAIT_DISP_LO;
        end
      end
      AWAIT_DISP_LO: begin
        held_low = b;
        if (held_modrm[7:6] == MOD_DISP8) begin
          rec      = regmem_rec(held_opcode, held_modrm, {{8{b[7]}}, b}, 1'b0);
          produced = 1'b1;
          phase    = AWAIT_OPCODE;
        end else begin
          phase = AWAIT_DISP_HI;
        end
      end
      AWAIT_DISP_HI: begin
        rec      = regmem_rec(held_opcode, held_modrm, {b, held_low}, 1'b0);
        produced = 1'b1;
        phase    = AWAIT_OPCODE;
      end
      AWAIT_IMM_LO: begin
        held_low = b;
        if (!held_opcode[3]) begin
          rec      = imm_rec(held_opcode, {8'h00, b}, 1'b0);
          produced = 1'b1;
          phase    = AWAIT_OPCODE;
        end else begin
          phase = AWAIT_IMM_HI;
        end
      end
      AWAIT_IMM_HI: begin
        rec      = imm_rec(held_opcode, {b, held_low}, 1'b0);
        produced = 1'b1;
        phase    = AWAIT_OPCODE;
      end
      AWAIT_ADDR_LO: begin
        held_low = b;
        phase    = AWAIT_ADDR_HI;
      end
      default: begin
        rec      = acc_rec(held_opcode, {b, held_low}, 1'b0);
        produced = 1'b1;
        phase    = AWAIT_OPCODE;
      end
    endcase
    if (last && !produced && phase != AWAIT_OPCODE) begin
      case (phase)
        AWAIT_MODRM:                 rec = regmem_rec(held_opcode, 8'h00, 16'h0000, 1'b1);
        AWAIT_DISP_LO, AWAIT_DISP_HI: rec = regmem_rec(held_opcode, held_modrm, 16'h0000, 1'b1);
        AWAIT_IMM_LO, AWAIT_IMM_HI:   rec = imm_rec(held_opcode, 16'h0000, 1'b1);
        default:                     rec = acc_rec(held_opcode, 16'h0000, 1'b1);
      endcase
      produced = 1'b1;
    end
    if (last) phase = AWAIT_OPCODE;
    return produced;
  endfunction

  task automatic report_mismatch(input string field, input int unsigned got,
                                 input int unsigned want);
    $display("record %0d: %s is 0x%0h, expected 0x%0h", record_count, field, got, want);
    error_count++;
  endtask

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stalled_cycles <= 0;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
  end

  initial begin
    while (stalled_cycles < WATCHDOG_LIMIT) @(posedge clk_i);
    $display("Some tests failed");
    $finish;
  end

  // Record sink: random stalls, field-by-field check against the oldest expectation.
  initial begin
    int unsigned gap;
    int unsigned n;
    bit          no_stall;
    dec_rec_t    want;
    logic [OUT_TDATA_W-1:0] got;
    logic        got_trunc;
    n        = 0;
    no_stall = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (n % 32 == 0) no_stall = ($urandom_range(0, 3) == 0);
      gap = no_stall ? 0 : $urandom_range(0, 19);
      n++;
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      got       = m_axis_tdata;
      got_trunc = m_axis_tuser;
      if (pending_records.size() == 0) begin
        report_mismatch("unexpected record", got[31:0], 0);
      end else begin
        want = pending_records.pop_front();
        if (got[1:0] != want.form)
          report_mismatch("form", 32'(got[1:0]), 32'(want.form));
        if (got[2] != want.to_register)
          report_mismatch("to_register", 32'(got[2]), 32'(want.to_register));
        if (got[3] != want.wide) report_mismatch("wide", 32'(got[3]), 32'(want.wide));
        if (got[6:4] != want.reg_field)
          report_mismatch("reg_field", 32'(got[6:4]), 32'(want.reg_field));
        if (got[8:7] != want.mode) report_mismatch("mode", 32'(got[8:7]), 32'(want.mode));
        if (got[11:9] != want.rm_code)
          report_mismatch("rm_code", 32'(got[11:9]), 32'(want.rm_code));
        if (got[12] != want.direct_address)
          report_mismatch("direct_address", 32'(got[12]), 32'(want.direct_address));
        if (got[28:13] != want.offset_value)
          report_mismatch("offset_value", 32'(got[28:13]), 32'(want.offset_value));
        if (got[44:29] != want.immediate)
          report_mismatch("immediate", 32'(got[44:29]), 32'(want.immediate));
        if (got[47:45] != 3'd0) report_mismatch("padding", 32'(got[47:45]), 0);
        if (got_trunc != want.truncated)
          report_mismatch("truncated", 32'(got_trunc), 32'(want.truncated));
      end
      record_count++;
    end
  end

  initial begin
    logic [7:0]  ins[$];
    logic [7:0]  op;
    logic [7:0]  modrm;
    int unsigned pick;
    int unsigned cut;
    int unsigned gap;
    int unsigned n;
    bit          end_here;
    bit          no_idle;
    bit          produced;
    dec_rec_t    rec;
    code_word_t  w;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (DIRECTED[i]) byte_stream.push_back(DIRECTED[i]);
    while (byte_stream.size() < DIRECTED_LEN + RANDOM_WORDS) begin
      ins.delete();
      pick = $urandom_range(0, 15);
      if (pick < 6) begin
        op    = OP_RM_LO + 8'($urandom_range(0, 3));
        modrm = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 7) == 0) modrm = {MOD_NO_DISP, modrm[5:3], RM_DIRECT};
        ins.push_back(op);
        ins.push_back(modrm);
        if (modrm[7:6] == MOD_DISP8) begin
          ins.push_back(8'($urandom_range(0, 255)));
        end else if (modrm[7:6] == MOD_DISP16 ||
                     (modrm[7:6] == MOD_NO_DISP && modrm[2:0] == RM_DIRECT)) begin
          ins.push_back(8'($urandom_range(0, 255)));
          ins.push_back(8'($urandom_range(0, 255)));
        end
      end else if (pick < 10) begin
        op = OP_IMM_LO + 8'($urandom_range(0, 15));
        ins.push_back(op);
        ins.push_back(8'($urandom_range(0, 255)));
        if (op[3]) ins.push_back(8'($urandom_range(0, 255)));
      end else if (pick < 13) begin
        op = OP_ACC_LO + 8'($urandom_range(0, 3));
        ins.push_back(op);
        ins.push_back(8'($urandom_range(0, 255)));
        ins.push_back(8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 3)) ins.push_back(8'($urandom_range(0, 255)));
      end
      cut = ins.size();
      if ($urandom_range(0, 9) == 0) cut = $urandom_range(1, ins.size());
      end_here = (cut < ins.size()) || ($urandom_range(0, 15) == 0);
      for (int i = 0; i < cut; i++) begin
        byte_stream.push_back('{ins[i], end_here && (i == cut - 1), 1'b0, NO_REC});
      end
    end

    @(posedge clk_i);
    n       = 0;
    no_idle = 1'b0;
    while (byte_stream.size() > 0) begin
      w = byte_stream.pop_front();
      if (n % 32 == 0) no_idle = ($urandom_range(0, 3) == 0);
      gap = no_idle ? 0 : $urandom_range(0, 19);
      n++;
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= w.code;
      s_axis_tlast  <= w.last;
      @(posedge clk_i);
      while (!s_axis_tready) @(posedge clk_i);
      produced = decode_byte(w.code, w.last, rec);
      if (w.typed) begin
        pending_records.push_back(w.want);
      end else if (produced) begin
        pending_records.push_back(rec);
      end
    end
    s_axis_tvalid <= 1'b0;
    s_axis_tlast  <= 1'b0;

    while (pending_records.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/movdec_pkg.sv
hdl/movdec_front.sv
hdl/movdec_queue.sv
hdl/movdec_back.sv
hdl/mov_instruction_decoder.sv
verif/mov_instruction_decoder_test.sv
